@@ hw/rtl/relay_unit_link_controller_core_assert.svh @@
// ----------------------------------------------------------------------------
// Relay unit link controller assertion macros
// Shared property forms for the checks in the core.
// ----------------------------------------------------------------------------
`ifndef RELAY_UNIT_LINK_CONTROLLER_CORE_ASSERT_SVH
`define RELAY_UNIT_LINK_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication
`define RULC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rulc check failed");

// next-cycle implication
`define RULC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rulc check failed");

`endif

@@ hw/rtl/rulc_pkg.sv @@
// ----------------------------------------------------------------------------
// rulc_pkg
// Types, codes and constants shared by the relay unit link controller.
// ----------------------------------------------------------------------------
package rulc_pkg;

    localparam int NUM_OUTPUTS = 16;
    localparam int NUM_INPUTS  = 8;
    localparam int INIT_LEN    = 14;
    localparam int PERIOD_W    = 14;

    localparam logic [2:0] OP_RX    = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_PULSE = 3'd2;
    localparam logic [2:0] OP_GETO  = 3'd3;
    localparam logic [2:0] OP_GETI  = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;
    localparam logic [2:0] OP_START = 3'd6;

    localparam logic [2:0] K_TX     = 3'd0;
    localparam logic [2:0] K_SETD   = 3'd1;
    localparam logic [2:0] K_OLVL   = 3'd2;
    localparam logic [2:0] K_PULSED = 3'd3;
    localparam logic [2:0] K_ILVL   = 3'd4;

    localparam logic [0:0] REG_RETRY      = 1'b0;
    localparam logic [0:0] REG_LONG_RETRY = 1'b1;

    localparam logic [PERIOD_W-1:0] RETRY_RESET      = 14'd1000;
    localparam logic [PERIOD_W-1:0] LONG_RETRY_RESET = 14'd10000;

    typedef enum logic [3:0] {
        C_NONE, C_FLUSH, C_RX_PULSE, C_RX_REPORT, C_RX_INPUT, C_INIT_BYTE,
        C_INIT_SET, C_SET_A, C_SET_B, C_PULSE, C_GET_OUT, C_GET_IN,
        C_TICK, C_START_RD
    } t_code;

    typedef enum logic [2:0] {
        RX_NONE, RX_PULSE, RX_REPORT, RX_INPUT, RX_INIT
    } t_rx_class;

    typedef struct packed {
        logic       load;
        t_code      code;
        logic [3:0] idx;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        t_rx_class  rx_class;
        logic       set_cond;
        logic       step_ok;
    } t_status;

    function automatic logic [7:0] init_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h54;
            4'd1:    b = 8'h5A;
            4'd2:    b = 8'h57;
            4'd3:    b = 8'h55;
            4'd4:    b = 8'h56;
            4'd5:    b = 8'h52;
            4'd6:    b = 8'h56;
            4'd7:    b = 8'h5A;
            4'd8:    b = 8'h57;
            4'd9:    b = 8'h55;
            4'd10:   b = 8'h56;
            4'd11:   b = 8'h52;
            4'd12:   b = 8'h52;
            4'd13:   b = 8'h51;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/rulc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rulc_ctrl
// Sequencer: walks the steps of one transaction and issues datapath commands.
// ----------------------------------------------------------------------------
module rulc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rulc_pkg::t_status i_status,
    output rulc_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SINGLE, S_SET_B, S_START_RD, S_INIT_BYTE,
        S_INIT_SET, S_TICK, S_FLUSH
    } t_state;

    localparam logic [3:0] LAST_OUT  = 4'(rulc_pkg::NUM_OUTPUTS - 1);
    localparam logic [3:0] LAST_INIT = 4'(rulc_pkg::INIT_LEN - 1);

    t_state     r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic [1:0] r_k, n_k;
    rulc_pkg::t_code single_code;

    // hold off new transactions during reset as well
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    always_comb begin
        case (i_status.op)
            rulc_pkg::OP_RX: begin
                case (i_status.rx_class)
                    rulc_pkg::RX_PULSE:  single_code = rulc_pkg::C_RX_PULSE;
                    rulc_pkg::RX_REPORT: single_code = rulc_pkg::C_RX_REPORT;
                    rulc_pkg::RX_INPUT:  single_code = rulc_pkg::C_RX_INPUT;
                    default:             single_code = rulc_pkg::C_NONE;
                endcase
            end
            rulc_pkg::OP_SET:   single_code = rulc_pkg::C_SET_A;
            rulc_pkg::OP_PULSE: single_code = rulc_pkg::C_PULSE;
            rulc_pkg::OP_GETO:  single_code = rulc_pkg::C_GET_OUT;
            rulc_pkg::OP_GETI:  single_code = rulc_pkg::C_GET_IN;
            default:            single_code = rulc_pkg::C_NONE;
        endcase
    end

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_valid && i_rst_n;
        o_cmd.idx  = r_idx;
        o_cmd.k    = r_k;
        case (r_state)
            S_SINGLE:    o_cmd.code = single_code;
            S_SET_B:     o_cmd.code = rulc_pkg::C_SET_B;
            S_START_RD:  o_cmd.code = rulc_pkg::C_START_RD;
            S_INIT_BYTE: o_cmd.code = rulc_pkg::C_INIT_BYTE;
            S_INIT_SET:  o_cmd.code = rulc_pkg::C_INIT_SET;
            S_TICK:      o_cmd.code = rulc_pkg::C_TICK;
            S_FLUSH:     o_cmd.code = rulc_pkg::C_FLUSH;
            default:     o_cmd.code = rulc_pkg::C_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_idx = 4'd0;
                n_k   = 2'd0;
                case (i_status.op)
                    rulc_pkg::OP_RX: begin
                        if (i_status.rx_class == rulc_pkg::RX_INIT) begin
                            n_state = S_INIT_BYTE;
                        end else if (i_status.rx_class == rulc_pkg::RX_NONE) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_state = S_SINGLE;
                        end
                    end
                    rulc_pkg::OP_TICK:  n_state = S_TICK;
                    rulc_pkg::OP_START: n_state = S_START_RD;
                    rulc_pkg::OP_SET, rulc_pkg::OP_PULSE,
                    rulc_pkg::OP_GETO, rulc_pkg::OP_GETI: n_state = S_SINGLE;
                    default:            n_state = S_FLUSH;
                endcase
            end
            S_SINGLE: begin
                if (i_status.step_ok) begin
                    if (i_status.op == rulc_pkg::OP_SET && i_status.set_cond) begin
                        n_state = S_SET_B;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_SET_B: begin
                if (i_status.step_ok) begin
                    n_state = S_FLUSH;
                end
            end
            S_START_RD: begin
                if (i_status.step_ok) begin
                    if (r_idx == LAST_OUT) begin
                        n_idx   = 4'd0;
                        n_state = S_INIT_BYTE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_INIT_BYTE: begin
                if (i_status.step_ok) begin
                    if (r_idx == LAST_INIT) begin
                        n_idx   = 4'd0;
                        n_state = S_INIT_SET;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_INIT_SET: begin
                if (i_status.step_ok) begin
                    if (r_idx == LAST_OUT) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_TICK: begin
                if (i_status.step_ok) begin
                    if (r_k == 2'd2) begin
                        n_k = 2'd0;
                        if (r_idx == LAST_OUT) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx = r_idx + 4'd1;
                        end
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.step_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 4'd0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
        end
    end

endmodule

@@ hw/rtl/rulc_dp.sv @@
// ----------------------------------------------------------------------------
// rulc_dp
// Per-output state, retry countdowns, result hold slot and output register.
// ----------------------------------------------------------------------------
module rulc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [13:0]       i_cfg_data,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_rx_byte,
    input  logic [3:0]        i_channel,
    input  logic              i_level,
    input  logic              i_long_pulse,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_tx_byte,
    output logic [3:0]        o_reply_channel,
    output logic              o_reply_level,
    output logic              o_last,
    input  rulc_pkg::t_cmd    i_cmd,
    output rulc_pkg::t_status o_status
);

    localparam int NO = rulc_pkg::NUM_OUTPUTS;
    localparam int NI = rulc_pkg::NUM_INPUTS;

    logic [13:0] r_retry, r_long_retry;
    logic [2:0]  r_op;
    logic [7:0]  r_byte;
    logic [3:0]  r_ch;
    logic        r_level, r_lp;

    logic [NO-1:0] r_lvl, r_rp, r_sp;
    logic [1:0]    r_mode [NO];
    logic [2:0]    r_mark [NO];
    logic [13:0]   r_cd0 [NO];
    logic [13:0]   r_cd1 [NO];
    logic [13:0]   r_cd2 [NO];
    logic [NI-1:0] r_inl;

    logic        r_hv;
    logic [2:0]  r_hkind;
    logic [7:0]  r_hbyte;
    logic [3:0]  r_hch;
    logic        r_hlvl;

    logic [3:0]  ix;
    logic        rp, sp, lv, rng, v, pend, set_cond;
    logic [1:0]  md;
    logic [2:0]  mk;
    logic [13:0] per_s, per_l, per_k, cnt;
    logic        e_v;
    logic [2:0]  e_kind;
    logic [7:0]  e_byte;
    logic [3:0]  e_ch;
    logic        e_lvl;
    logic        out_free, step_ok, go;
    rulc_pkg::t_rx_class rx_class;

    assign per_s = (r_retry == 14'd0) ? 14'd1 : r_retry;
    assign per_l = (r_long_retry == 14'd0) ? 14'd1 : r_long_retry;

    always_comb begin
        case (r_byte[7:4])
            4'h1:       rx_class = ({1'b0, r_byte[3:0]} < 5'(NO)) ?
                                   rulc_pkg::RX_PULSE : rulc_pkg::RX_NONE;
            4'h2, 4'h3: rx_class = ({1'b0, r_byte[3:0]} < 5'(NO)) ?
                                   rulc_pkg::RX_REPORT : rulc_pkg::RX_NONE;
            4'h6:       rx_class = ({1'b0, r_byte[2:0]} < 4'(NI)) ?
                                   rulc_pkg::RX_INPUT : rulc_pkg::RX_NONE;
            4'h0, 4'h4: rx_class = rulc_pkg::RX_NONE;
            4'h5:       rx_class = (r_byte == 8'h51) ? rulc_pkg::RX_NONE : rulc_pkg::RX_INIT;
            default:    rx_class = rulc_pkg::RX_INIT;
        endcase
    end

    always_comb begin
        case (i_cmd.code)
            rulc_pkg::C_TICK, rulc_pkg::C_START_RD, rulc_pkg::C_INIT_SET: ix = i_cmd.idx;
            rulc_pkg::C_RX_PULSE, rulc_pkg::C_RX_REPORT:                 ix = r_byte[3:0];
            default:                                                     ix = r_ch;
        endcase
    end

    assign rp  = r_rp[ix];
    assign sp  = r_sp[ix];
    assign lv  = r_lvl[ix];
    assign md  = r_mode[ix];
    assign mk  = r_mark[ix];
    assign v   = r_byte[4];
    assign rng = ({1'b0, r_ch} < 5'(NO));
    assign set_cond = rng && (rp || (lv != r_level));

    always_comb begin
        case (i_cmd.k)
            2'd0:    begin pend = rp;         cnt = r_cd0[ix]; per_k = per_s; end
            2'd1:    begin pend = sp;         cnt = r_cd1[ix]; per_k = per_s; end
            default: begin
                pend  = (md != 2'd0);
                cnt   = r_cd2[ix];
                per_k = (md == 2'd2) ? per_l : per_s;
            end
        endcase
    end

    always_comb begin
        e_v    = 1'b0;
        e_kind = rulc_pkg::K_TX;
        e_byte = 8'h00;
        e_ch   = 4'd0;
        e_lvl  = 1'b0;
        case (i_cmd.code)
            rulc_pkg::C_RX_PULSE: begin
                e_v = mk[2]; e_kind = rulc_pkg::K_PULSED; e_ch = ix;
            end
            rulc_pkg::C_RX_REPORT: begin
                if (rp) begin
                    e_v = mk[0]; e_kind = rulc_pkg::K_OLVL; e_ch = ix; e_lvl = v;
                end else if (lv == v) begin
                    e_v = mk[1]; e_kind = rulc_pkg::K_SETD; e_ch = ix;
                end else begin
                    e_v = !sp; e_byte = {3'b001, lv, ix};
                end
            end
            rulc_pkg::C_RX_INPUT: begin
                e_v = 1'b1; e_byte = r_byte;
            end
            rulc_pkg::C_INIT_BYTE: begin
                e_v = 1'b1; e_byte = rulc_pkg::init_byte(i_cmd.idx);
            end
            rulc_pkg::C_INIT_SET: begin
                e_v = !rp && !sp; e_byte = {3'b001, lv, ix};
            end
            rulc_pkg::C_SET_A: begin
                if (set_cond) begin
                    e_v = mk[0]; e_kind = rulc_pkg::K_OLVL; e_ch = ix; e_lvl = lv;
                end else begin
                    e_v = rng; e_kind = rulc_pkg::K_SETD; e_ch = ix;
                end
            end
            rulc_pkg::C_SET_B: begin
                e_v = rng && !sp; e_byte = {3'b001, r_level, ix};
            end
            rulc_pkg::C_PULSE: begin
                e_v = rng && (md == 2'd0); e_byte = {3'b000, r_lp, ix};
            end
            rulc_pkg::C_GET_OUT: begin
                e_v = rng && !rp; e_kind = rulc_pkg::K_OLVL; e_ch = ix; e_lvl = lv;
            end
            rulc_pkg::C_GET_IN: begin
                e_v = 1'b1; e_kind = rulc_pkg::K_ILVL; e_ch = r_ch;
                e_lvl = ({1'b0, r_ch} < 5'(NI)) ? r_inl[r_ch[2:0]] : 1'b0;
            end
            rulc_pkg::C_TICK: begin
                e_v = pend && (cnt <= 14'd1);
                case (i_cmd.k)
                    2'd0:    e_byte = {4'h7, ix};
                    2'd1:    e_byte = {3'b001, lv, ix};
                    default: e_byte = {3'b000, (md == 2'd2), ix};
                endcase
            end
            rulc_pkg::C_START_RD: begin
                e_v = !rp; e_byte = {4'h7, ix};
            end
            default: e_v = 1'b0;
        endcase
    end

    assign out_free = !o_valid || !i_stall;
    always_comb begin
        if (i_cmd.code == rulc_pkg::C_FLUSH) begin
            step_ok = !r_hv || out_free;
        end else begin
            step_ok = !e_v || !r_hv || out_free;
        end
    end
    assign go = step_ok && (i_cmd.code != rulc_pkg::C_NONE) &&
                (i_cmd.code != rulc_pkg::C_FLUSH);

    assign o_status.op       = r_op;
    assign o_status.rx_class = rx_class;
    assign o_status.set_cond = set_cond;
    assign o_status.step_ok  = step_ok;

    // item latch and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry      <= rulc_pkg::RETRY_RESET;
            r_long_retry <= rulc_pkg::LONG_RETRY_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rulc_pkg::REG_RETRY) begin
                r_retry <= i_cfg_data;
            end else begin
                r_long_retry <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_byte  <= i_rx_byte;
            r_ch    <= i_channel;
            r_level <= i_level;
            r_lp    <= i_long_pulse;
        end
    end

    // per-output state and input levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
            r_rp  <= '0;
            r_sp  <= '0;
            r_inl <= '0;
            for (int i = 0; i < NO; i++) begin
                r_mode[i] <= 2'd0;
                r_mark[i] <= 3'd0;
                r_cd0[i]  <= 14'd0;
                r_cd1[i]  <= 14'd0;
                r_cd2[i]  <= 14'd0;
            end
        end else if (go) begin
            case (i_cmd.code)
                rulc_pkg::C_RX_PULSE: begin
                    r_mode[ix]    <= 2'd0;
                    r_cd2[ix]     <= 14'd0;
                    r_mark[ix][2] <= 1'b0;
                end
                rulc_pkg::C_RX_REPORT: begin
                    if (rp) begin
                        r_lvl[ix]     <= v;
                        r_rp[ix]      <= 1'b0;
                        r_cd0[ix]     <= 14'd0;
                        r_mark[ix][0] <= 1'b0;
                    end else if (lv == v) begin
                        r_sp[ix]      <= 1'b0;
                        r_cd1[ix]     <= 14'd0;
                        r_mark[ix][1] <= 1'b0;
                    end else if (!sp) begin
                        r_sp[ix]  <= 1'b1;
                        r_cd1[ix] <= per_s;
                    end
                end
                rulc_pkg::C_RX_INPUT: begin
                    r_inl[r_byte[2:0]] <= r_byte[3];
                end
                rulc_pkg::C_INIT_SET: begin
                    if (!rp && !sp) begin
                        r_sp[ix]  <= 1'b1;
                        r_cd1[ix] <= per_s;
                    end
                end
                rulc_pkg::C_SET_A: begin
                    if (set_cond) begin
                        r_rp[ix]      <= 1'b0;
                        r_cd0[ix]     <= 14'd0;
                        r_mark[ix][0] <= 1'b0;
                    end
                end
                rulc_pkg::C_SET_B: begin
                    if (rng) begin
                        r_lvl[ix]     <= r_level;
                        r_mark[ix][1] <= 1'b1;
                        if (!sp) begin
                            r_sp[ix]  <= 1'b1;
                            r_cd1[ix] <= per_s;
                        end
                    end
                end
                rulc_pkg::C_PULSE: begin
                    if (rng) begin
                        r_mark[ix][2] <= 1'b1;
                        if (md == 2'd0) begin
                            r_mode[ix] <= {r_lp, !r_lp};
                            r_cd2[ix]  <= r_lp ? per_l : per_s;
                        end
                    end
                end
                rulc_pkg::C_GET_OUT: begin
                    if (rng && rp) begin
                        r_mark[ix][0] <= 1'b1;
                    end
                end
                rulc_pkg::C_TICK: begin
                    logic [13:0] nc;
                    nc = (!pend) ? 14'd0 : ((cnt <= 14'd1) ? per_k : cnt - 14'd1);
                    case (i_cmd.k)
                        2'd0:    r_cd0[ix] <= nc;
                        2'd1:    r_cd1[ix] <= nc;
                        default: r_cd2[ix] <= nc;
                    endcase
                end
                rulc_pkg::C_START_RD: begin
                    if (!rp) begin
                        r_rp[ix]  <= 1'b1;
                        r_cd0[ix] <= per_s;
                    end
                end
                default: r_rp <= r_rp;
            endcase
        end
    end

    // hold slot: a result moves out with last clear once the next one exists
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_cmd.code == rulc_pkg::C_FLUSH) begin
            if (r_hv && out_free) begin
                o_valid <= 1'b1;
                r_hv    <= 1'b0;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end else if (go && e_v) begin
            r_hv <= 1'b1;
            if (r_hv) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end else if (o_valid && !i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.code == rulc_pkg::C_FLUSH && r_hv && out_free) ||
            (go && e_v && r_hv)) begin
            o_kind          <= r_hkind;
            o_tx_byte       <= r_hbyte;
            o_reply_channel <= r_hch;
            o_reply_level   <= r_hlvl;
            o_last          <= (i_cmd.code == rulc_pkg::C_FLUSH);
        end
        if (go && e_v) begin
            r_hkind <= e_kind;
            r_hbyte <= e_byte;
            r_hch   <= e_ch;
            r_hlvl  <= e_lvl;
        end
    end

endmodule

@@ hw/rtl/relay_unit_link_controller_core.sv @@
// ----------------------------------------------------------------------------
// relay_unit_link_controller_core
// Host-side link controller for a serial relay unit, 16 outputs, 8 inputs.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; input stall stays high until its last
// result has moved into the output register, and also while reset is held.
// Each step of the sequencer yields at most one result. A transaction has
// 1 step for a command or received byte (2 for a set that changes the output
// or ends a pending read, none for an ignored byte or an unknown op), 48 for
// a tick (three timers for each output), 30 for a received init request and
// 46 for start. Output stall holds a step back only while the hold slot and
// the output register are both full. The last result of each transaction is
// held in a one-entry slot until the sequencer knows it is the last, then
// leaves with o_last set.
// ----------------------------------------------------------------------------
module relay_unit_link_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_rx_byte,
    input  logic [3:0]  i_channel,
    input  logic        i_level,
    input  logic        i_long_pulse,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [3:0]  o_reply_channel,
    output logic        o_reply_level,
    output logic        o_last
);

    rulc_pkg::t_cmd    cmd;
    rulc_pkg::t_status status;

    rulc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rulc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_rx_byte       (i_rx_byte),
        .i_channel       (i_channel),
        .i_level         (i_level),
        .i_long_pulse    (i_long_pulse),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_reply_channel (o_reply_channel),
        .o_reply_level   (o_reply_level),
        .o_last          (o_last),
        .i_cmd           (cmd),
        .o_status        (status)
    );

`include "relay_unit_link_controller_core_assert.svh"

    `RULC_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `RULC_ASSERT_NOW(a_event_no_byte, o_valid && (o_kind != rulc_pkg::K_TX), o_tx_byte == 8'h00)
    `RULC_ASSERT_NOW(a_tx_no_reply, o_valid && (o_kind == rulc_pkg::K_TX),
                     (o_reply_channel == 4'd0) && !o_reply_level)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Relay unit link controller testbench
// Drives link bytes, host commands, ticks and start commands with random
// gaps and output stalls, predicts every link byte and completion event, and
// checks each result field by field against the predicted stream.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic [3:0] chan;
        logic       lvl;
        logic       last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [13:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_op = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [3:0]  i_channel = '0;
    logic        i_level = 1'b0;
    logic        i_long_pulse = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [3:0]  o_reply_channel;
    logic        o_reply_level;
    logic        o_last;

    relay_unit_link_controller_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic        lvl_q   [rulc_pkg::NUM_OUTPUTS];
    logic        rd_pend [rulc_pkg::NUM_OUTPUTS];
    logic        st_pend [rulc_pkg::NUM_OUTPUTS];
    logic [1:0]  pmode   [rulc_pkg::NUM_OUTPUTS];
    logic [2:0]  waiters [rulc_pkg::NUM_OUTPUTS];
    logic [13:0] cdown   [rulc_pkg::NUM_OUTPUTS][3];
    logic        in_lvl  [rulc_pkg::NUM_INPUTS];
    logic [13:0] per_short, per_long;

    t_result expected_q[$];
    t_result item_res[$];
    int errors = 0, n_items = 0, n_results = 0, idle_cycles = 0;
    int stall_left = 0;
    bit ticked = 0;

    function automatic logic [7:0] init_char(int i);
        string s;
        s = "TZWUVRVZWUVRRQ";
        return s[i];
    endfunction

    function automatic logic [13:0] eff(logic [13:0] p);
        return (p == 0) ? 14'd1 : p;
    endfunction

    function automatic void push(logic [2:0] k, logic [7:0] b, logic [3:0] c, logic l);
        t_result r;
        r = '{k, b, c, l, 1'b0};
        item_res.push_back(r);
    endfunction

    function automatic void tx_read(int i);
        push(rulc_pkg::K_TX, 8'h70 | i, 0, 0);
    endfunction
    function automatic void tx_set(int i);
        push(rulc_pkg::K_TX, 8'h20 | i | (lvl_q[i] << 4), 0, 0);
    endfunction
    function automatic void tx_pulse(int i);
        push(rulc_pkg::K_TX, i | ((pmode[i] == 2) << 4), 0, 0);
    endfunction

    function automatic void queue_set(int i);
        if (!st_pend[i]) begin
            tx_set(i);
            cdown[i][1] = eff(per_short);
            st_pend[i] = 1;
        end
    endfunction

    function automatic void finish_read(int i);
        rd_pend[i] = 0;
        cdown[i][0] = 0;
        if (waiters[i][0]) push(rulc_pkg::K_OLVL, 0, i, lvl_q[i]);
        waiters[i][0] = 0;
    endfunction

    function automatic void finish_set(int i);
        st_pend[i] = 0;
        cdown[i][1] = 0;
        if (waiters[i][1]) push(rulc_pkg::K_SETD, 0, i, 0);
        waiters[i][1] = 0;
    endfunction

    function automatic void init_sequence();
        for (int i = 0; i < rulc_pkg::INIT_LEN; i++) push(rulc_pkg::K_TX, init_char(i), 0, 0);
        for (int i = 0; i < rulc_pkg::NUM_OUTPUTS; i++) if (!rd_pend[i]) queue_set(i);
    endfunction

    function automatic bit timer_fires(int i, int k, bit pend, logic [13:0] p);
        if (!pend) begin
            cdown[i][k] = 0;
            return 0;
        end
        if (cdown[i][k] <= 1) begin
            cdown[i][k] = eff(p);
            return 1;
        end
        cdown[i][k]--;
        return 0;
    endfunction

    function automatic void predict_link(logic [2:0] op, logic [7:0] b, logic [3:0] ch,
                                         logic lv, logic lp);
        int oi, ii;
        oi = b[3:0];
        ii = b[2:0];
        item_res.delete();
        case (op)
            rulc_pkg::OP_RX: begin
                case (b[7:4])
                    4'h0, 4'h4: ;
                    4'h1: begin
                        pmode[oi] = 0;
                        cdown[oi][2] = 0;
                        if (waiters[oi][2]) push(rulc_pkg::K_PULSED, 0, oi, 0);
                        waiters[oi][2] = 0;
                    end
                    4'h2, 4'h3: begin
                        if (rd_pend[oi]) begin
                            lvl_q[oi] = b[4];
                            finish_read(oi);
                        end else if (lvl_q[oi] == b[4]) finish_set(oi);
                        else queue_set(oi);
                    end
                    4'h6: begin
                        in_lvl[ii] = b[3];
                        push(rulc_pkg::K_TX, 8'h60 | ii | (b[3] << 3), 0, 0);
                    end
                    default: if (b != 8'h51) init_sequence();
                endcase
            end
            rulc_pkg::OP_SET: begin
                if (rd_pend[ch] || lvl_q[ch] != lv) begin
                    finish_read(ch);
                    lvl_q[ch] = lv;
                    queue_set(ch);
                    waiters[ch][1] = 1;
                end else push(rulc_pkg::K_SETD, 0, ch, 0);
            end
            rulc_pkg::OP_PULSE: begin
                if (pmode[ch] == 0) begin
                    pmode[ch] = lp + 1;
                    tx_pulse(ch);
                    cdown[ch][2] = eff(lp ? per_long : per_short);
                end
                waiters[ch][2] = 1;
            end
            rulc_pkg::OP_GETO: begin
                if (!rd_pend[ch]) push(rulc_pkg::K_OLVL, 0, ch, lvl_q[ch]);
                else waiters[ch][0] = 1;
            end
            rulc_pkg::OP_GETI: push(rulc_pkg::K_ILVL, 0, ch,
                                    ch < rulc_pkg::NUM_INPUTS ? in_lvl[ch[2:0]] : 1'b0);
            rulc_pkg::OP_TICK: begin
                for (int i = 0; i < rulc_pkg::NUM_OUTPUTS; i++) begin
                    if (timer_fires(i, 0, rd_pend[i], per_short)) tx_read(i);
                    if (timer_fires(i, 1, st_pend[i], per_short)) tx_set(i);
                    if (timer_fires(i, 2, pmode[i] != 0,
                                    pmode[i] == 2 ? per_long : per_short)) tx_pulse(i);
                end
            end
            rulc_pkg::OP_START: begin
                for (int i = 0; i < rulc_pkg::NUM_OUTPUTS; i++) begin
                    if (!rd_pend[i]) begin
                        tx_read(i);
                        cdown[i][0] = eff(per_short);
                        rd_pend[i] = 1;
                    end
                end
                init_sequence();
            end
            default: ;
        endcase
        if (item_res.size() > 0) item_res[item_res.size()-1].last = 1;
        foreach (item_res[j]) expected_q.push_back(item_res[j]);
    endfunction

    task automatic report_mismatch(string what, t_result got, t_result exp);
        errors++;
        $display("mismatch %s: got k%0d b%02h c%0d l%0d e%0d, exp k%0d b%02h c%0d l%0d e%0d",
                 what, got.kind, got.tx_byte, got.chan, got.lvl, got.last,
                 exp.kind, exp.tx_byte, exp.chan, exp.lvl, exp.last);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result checker and output stall
    always @(posedge i_clk) begin
        t_result got, exp;
        int g;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_kind, o_tx_byte, o_reply_channel, o_reply_level, o_last};
                n_results++;
                if (expected_q.size() == 0) report_mismatch("unexpected", got, got);
                else begin
                    exp = expected_q.pop_front();
                    if (got !== exp) report_mismatch("field", got, exp);
                end
            end
            // stall in runs: mostly short, now and then long
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                g = gap_len();
                i_stall <= (g != 0);
                stall_left <= (g > 0) ? g - 1 : 0;
            end
        end
    end

    // watchdog: no transaction either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op, logic [7:0] b, logic [3:0] ch,
                             logic lv, logic lp);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_rx_byte <= b;
        i_channel <= ch;
        i_level <= lv;
        i_long_pulse <= lp;
        do @(posedge i_clk); while (o_stall);
        predict_link(op, b, ch, lv, lp);
        n_items++;
        if (op == rulc_pkg::OP_TICK) ticked = 1;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [13:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rulc_pkg::REG_RETRY) per_short = val;
        else per_long = val;
    endtask

    task automatic test_directed();
        send_item(rulc_pkg::OP_GETO, 8'h00, 4'd15, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_GETI, 8'hFF, 4'd15, 1'b1, 1'b1);   // input out of range
        send_item(3'd7, 8'hAA, 4'd3, 1'b1, 1'b1);                 // unknown op
        send_item(rulc_pkg::OP_START, 8'h00, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_GETO, 8'h00, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_GETO, 8'h00, 4'd0, 1'b0, 1'b0);    // waiters collapse
        send_item(rulc_pkg::OP_RX, 8'h30, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_SET, 8'h00, 4'd1, 1'b1, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'h31, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_PULSE, 8'h00, 4'd2, 1'b0, 1'b1);
        send_item(rulc_pkg::OP_PULSE, 8'h00, 4'd2, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'h12, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'h6F, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_GETI, 8'h00, 4'd7, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'h51, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'h4F, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'h0F, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_RX, 8'hFF, 4'd0, 1'b0, 1'b0);      // resend init
        send_item(rulc_pkg::OP_TICK, 8'h00, 4'd0, 1'b0, 1'b0);
        send_item(rulc_pkg::OP_TICK, 8'h00, 4'd0, 1'b0, 1'b0);
    endtask

    task automatic test_zero_period();
        write_reg(rulc_pkg::REG_RETRY, 14'd0);
        write_reg(rulc_pkg::REG_LONG_RETRY, 14'd0);
        send_item(rulc_pkg::OP_PULSE, 8'h00, 4'd5, 1'b0, 1'b1);
        repeat (3) send_item(rulc_pkg::OP_TICK, 8'h00, 4'd0, 1'b0, 1'b0);
    endtask

    task automatic random_phase(int count);
        logic [2:0] op;
        logic [7:0] b;
        logic [3:0] ch;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            ch = $urandom;
            b = $urandom;
            if (r < 30) begin
                // plausible reply from the unit
                case ($urandom_range(0, 3))
                    0: b = {3'b001, 1'($urandom), ch};
                    1: b = {4'h1, ch};
                    2: b = {4'h6, 4'($urandom)};
                    default: ;
                endcase
                op = rulc_pkg::OP_RX;
            end else if (r < 40) op = rulc_pkg::OP_SET;
            else if (r < 50) op = rulc_pkg::OP_PULSE;
            else if (r < 60) op = rulc_pkg::OP_GETO;
            else if (r < 67) op = rulc_pkg::OP_GETI;
            else if (r < 95) op = rulc_pkg::OP_TICK;
            else if (r < 98) op = rulc_pkg::OP_START;
            else op = 3'd7;
            send_item(op, b, ch, 1'($urandom), 1'($urandom));
            if (n == count / 2) drain();   // hold sender until all results are in
        end
    endtask

    initial begin
        for (int i = 0; i < rulc_pkg::NUM_OUTPUTS; i++) begin
            lvl_q[i] = 0; rd_pend[i] = 0; st_pend[i] = 0; pmode[i] = 0; waiters[i] = 0;
            for (int k = 0; k < 3; k++) cdown[i][k] = 0;
        end
        for (int i = 0; i < rulc_pkg::NUM_INPUTS; i++) in_lvl[i] = 0;
        per_short = rulc_pkg::RETRY_RESET;
        per_long = rulc_pkg::LONG_RETRY_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_reg(rulc_pkg::REG_RETRY, 14'd2);
        write_reg(rulc_pkg::REG_LONG_RETRY, 14'd5);
        random_phase(110);
        test_zero_period();
        random_phase(60);
        write_reg(rulc_pkg::REG_RETRY, 14'h3FFF);
        write_reg(rulc_pkg::REG_LONG_RETRY, 14'h3FFF);
        random_phase(40);
        write_reg(rulc_pkg::REG_RETRY, 14'd3);
        write_reg(rulc_pkg::REG_LONG_RETRY, 14'd1);
        random_phase(70);
        drain();

        $display("covered %0d transactions in, %0d results out, periods 0 to max",
                 n_items, n_results);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
